// ----- design/epr_pkg.sv -----
// Shared constants, types and coefficient helpers for the precession rotator.
// No dependencies; every other design file refers to it by scoped names.
package epr_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int MAT_W = 32;
  localparam int MAT_FRAC = 30;
  localparam int PROD_W = COORD_WIDTH + MAT_W;
  localparam int SUM_W = PROD_W + 2;

  localparam int EPOCH_W = 38;
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 4;
  localparam logic [EPOCH_W-1:0] EPOCH_J2000 = 38'd160664453120;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W = 34;
  localparam int CORDIC_IW = 5;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1};

  // constant divisions as reciprocal multiplies: floor(n * R >> RECIP_SH)
  // is exact for n < 2^57; the turn divisor 1296000 is 10125 << 7
  localparam int RECIP_SH = 73;
  localparam int TURN_PRESH = 7;
  localparam logic [127:0] DIV_CENT = 128'd36525;
  localparam logic [127:0] DIV_TURN_ODD = 128'd10125;
  localparam logic [63:0] RECIP_CENT =
    64'(((128'd1 << RECIP_SH) + DIV_CENT - 128'd1) / DIV_CENT);
  localparam logic [63:0] RECIP_TURN =
    64'(((128'd1 << RECIP_SH) + DIV_TURN_ODD - 128'd1) / DIV_TURN_ODD);

  // micro-units to Q32, round half up
  function automatic logic signed [63:0] coef(input logic [63:0] micro);
    logic [63:0] v;
    v = ((micro << 32) + 64'd500000) / 64'd1000000;
    return signed'(v);
  endfunction

  localparam logic signed [63:0] K_LIN0 = coef(64'd2306218100);
  localparam logic signed [63:0] K_LIN1 = coef(64'd1396560);
  localparam logic signed [63:0] K_LIN2 = coef(64'd139);
  localparam logic signed [63:0] K_ZE2 = coef(64'd301880);
  localparam logic signed [63:0] K_ZE2T = coef(64'd344);
  localparam logic signed [63:0] K_ZE3 = coef(64'd17998);
  localparam logic signed [63:0] K_Z2 = coef(64'd1094680);
  localparam logic signed [63:0] K_Z2T = coef(64'd66);
  localparam logic signed [63:0] K_Z3 = coef(64'd18203);
  localparam logic signed [63:0] K_TH1 = coef(64'd2004310900);
  localparam logic signed [63:0] K_TH1T = coef(64'd853300);
  localparam logic signed [63:0] K_TH217 = coef(64'd217);
  localparam logic signed [63:0] K_TH2 = coef(64'd426650);
  localparam logic signed [63:0] K_TH3 = coef(64'd41833);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic signed [MAT_W-1:0] c0;
    logic signed [MAT_W-1:0] c1;
    logic signed [MAT_W-1:0] c2;
  } row_t;

  typedef struct packed {
    logic ok;
    row_t [2:0] rows;
  } mat_t;

  typedef struct packed {
    logic adv;
    logic vp;
  } pipe_ctl_t;

endpackage

// ----- design/epr_in_if.sv -----
// Input channel: one vector word with valid/ready.
// Depends on epr_pkg for the coordinate type.
interface epr_in_if;
  logic valid;
  logic ready;
  epr_pkg::coord_t vec_x;
  epr_pkg::coord_t vec_y;
  epr_pkg::coord_t vec_z;
  modport source(output valid, output vec_x, output vec_y, output vec_z, input ready);
  modport sink(input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

// ----- design/epr_out_if.sv -----
// Result channel: one rotated vector word with valid/ready.
// Depends on epr_pkg for the coordinate type.
interface epr_out_if;
  logic valid;
  logic ready;
  epr_pkg::coord_t rot_x;
  epr_pkg::coord_t rot_y;
  epr_pkg::coord_t rot_z;
  modport source(output valid, output rot_x, output rot_y, output rot_z, input ready);
  modport sink(input valid, input rot_x, input rot_y, input rot_z, output ready);
endinterface

// ----- design/equatorial_precession_rotate.sv -----
// Top level of the equatorial precession rotator.
// Depends on epr_pkg, epr_in_if, epr_out_if, epr_mat_build, epr_lane, epr_merge.
//
// Usage:
//   in_ch  : one vector word (vec_x, vec_y, vec_z, signed Q2.30) per valid/ready.
//   out_ch : one rotated word (rot_x, rot_y, rot_z, saturated) per input word.
//   cfg_*  : APB-style port, epoch_from_jd at byte address 0, epoch_to_jd at 8.
//            Writes take setup and access cycles, pready is always high.
// The rotation matrix depends only on the two epochs. After reset and after
// every register write it is rebuilt by a serial sequencer (shift-add multiply
// steps, constant divisions as reciprocal multiplies, 30-step CORDIC), while
// in_ch.ready is low.
// Once built, one word is accepted per cycle while the output is not stalled:
// three lanes each form one row's dot product, and the output register merges
// them, after the lane product registers. When the receiver stalls, the result
// holds, and a word is still taken into an empty product stage before ready drops.
// Reset sets both epochs to J2000.0 and empties the pipeline.
module equatorial_precession_rotate (
  input  logic clk,
  input  logic rst_n,
  epr_in_if.sink in_ch,
  epr_out_if.source out_ch,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [epr_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [epr_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [epr_pkg::CFG_DW-1:0] cfg_prdata,
  output logic cfg_pready
);
  localparam int EW = epr_pkg::EPOCH_W;
  localparam logic REG_FROM = 1'b0;
  localparam logic REG_TO = 1'b1;

  logic [EW-1:0] from_r, to_r;
  logic boot_r, vp_r;
  logic wr, start, adv_o, stage_free, accept;
  epr_pkg::mat_t mat;
  epr_pkg::pipe_ctl_t ctl;
  epr_pkg::coord_t res [3];

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[3] == REG_TO) ? {{(epr_pkg::CFG_DW-EW){1'b0}}, to_r}
                                               : {{(epr_pkg::CFG_DW-EW){1'b0}}, from_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      from_r <= epr_pkg::EPOCH_J2000;
      to_r <= epr_pkg::EPOCH_J2000;
      boot_r <= 1'b1;
    end else begin
      boot_r <= 1'b0;
      if (wr) begin
        case (cfg_paddr[3])
          REG_FROM: from_r <= cfg_pwdata[EW-1:0];
          REG_TO: to_r <= cfg_pwdata[EW-1:0];
          default: ;
        endcase
      end
    end
  end

  assign start = boot_r || wr;

  epr_mat_build u_build (
    .clk(clk), .rst_n(rst_n), .start(start),
    .epoch_from(from_r), .epoch_to(to_r), .mat_o(mat)
  );

  assign adv_o = !out_ch.valid || out_ch.ready;
  assign stage_free = !vp_r || adv_o;
  assign in_ch.ready = mat.ok && stage_free;
  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) vp_r <= 1'b0;
    else if (stage_free) vp_r <= accept;
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    epr_lane u_lane (
      .clk(clk), .load(accept), .row_i(mat.rows[g]),
      .vx(in_ch.vec_x), .vy(in_ch.vec_y), .vz(in_ch.vec_z), .res_o(res[g])
    );
  end

  assign ctl.adv = adv_o;
  assign ctl.vp = vp_r;

  epr_merge u_merge (
    .clk(clk), .rst_n(rst_n), .ctl_i(ctl),
    .rx(res[0]), .ry(res[1]), .rz(res[2]), .out_ch(out_ch)
  );

  a_accept_needs_matrix: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> mat.ok)
    else $error("word accepted without a built matrix");

  a_write_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    wr |=> !in_ch.ready)
    else $error("input open right after a register write");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vp_r)
    else $error("accepted word lost from product stage");

  a_stage_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (vp_r && adv_o) |=> out_ch.valid)
    else $error("product stage did not reach the output");
endmodule

// ----- design/epr_cordic.sv -----
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on epr_pkg (gain, arctangent table, widths).
module epr_cordic (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [31:0] ang_i,
  output logic done_o,
  output logic signed [epr_pkg::CORDIC_W-1:0] sin_o,
  output logic signed [epr_pkg::CORDIC_W-1:0] cos_o
);
  localparam int CW = epr_pkg::CORDIC_W;
  localparam int IW = epr_pkg::CORDIC_IW;
  localparam logic [IW-1:0] I_LAST = IW'(epr_pkg::CORDIC_STEPS - 1);

  logic run_r, done_r, flip_r;
  logic [IW-1:0] i_r;
  logic signed [CW-1:0] x_r, y_r, z_r;

  logic [31:0] a_q, a_f;
  logic flip;
  logic signed [CW-1:0] dx, dy, at;

  always_comb begin
    a_q = ang_i + 32'h4000_0000;
    flip = a_q[31];
    a_f = flip ? ang_i + 32'h8000_0000 : ang_i;
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    at = signed'({{(CW-32){1'b0}}, epr_pkg::ATAN_TAB[i_r]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      i_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      done_r <= 1'b0;
      i_r <= '0;
    end else if (run_r) begin
      i_r <= i_r + IW'(1);
      if (i_r == I_LAST) begin
        run_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      flip_r <= flip;
      x_r <= epr_pkg::CORDIC_GAIN;
      y_r <= '0;
      z_r <= CW'(signed'(a_f));
    end else if (run_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  assign done_o = done_r;
  assign sin_o = flip_r ? -y_r : y_r;
  assign cos_o = flip_r ? -x_r : x_r;
endmodule

// ----- design/epr_mat_build.sv -----
// Matrix sequencer: century intervals, angle polynomials, sines and cosines
// and the nine matrix elements, using a shared serial multiplier (constant
// divisions run as reciprocal multiplies). Depends on epr_pkg and epr_cordic.
module epr_mat_build (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [epr_pkg::EPOCH_W-1:0] epoch_from,
  input  logic [epr_pkg::EPOCH_W-1:0] epoch_to,
  output epr_pkg::mat_t mat_o
);
  localparam int EW = epr_pkg::EPOCH_W;
  localparam int MW = epr_pkg::MAT_W;
  localparam int CW = epr_pkg::CORDIC_W;
  localparam int RS = epr_pkg::RECIP_SH;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ISSUE = 2'd1;
  localparam logic [1:0] PH_RUN = 2'd2;
  localparam logic [1:0] PH_WB = 2'd3;

  localparam logic [2:0] OP_M32 = 3'd0;
  localparam logic [2:0] OP_M30 = 3'd1;
  localparam logic [2:0] OP_DIV = 3'd2;
  localparam logic [2:0] OP_COR = 3'd3;
  localparam logic [2:0] OP_SET = 3'd4;

  localparam logic [5:0] S_T0 = 6'd0;
  localparam logic [5:0] S_T = 6'd1;
  localparam logic [5:0] S_T02 = 6'd2;
  localparam logic [5:0] S_T2 = 6'd3;
  localparam logic [5:0] S_T3 = 6'd4;
  localparam logic [5:0] S_LA = 6'd5;
  localparam logic [5:0] S_LB = 6'd6;
  localparam logic [5:0] S_LT = 6'd7;
  localparam logic [5:0] S_ZEA = 6'd8;
  localparam logic [5:0] S_ZEB = 6'd9;
  localparam logic [5:0] S_ZEC = 6'd10;
  localparam logic [5:0] S_ZED = 6'd11;
  localparam logic [5:0] S_ZEE = 6'd12;
  localparam logic [5:0] S_ZA = 6'd13;
  localparam logic [5:0] S_ZB = 6'd14;
  localparam logic [5:0] S_ZC = 6'd15;
  localparam logic [5:0] S_ZD = 6'd16;
  localparam logic [5:0] S_ZE = 6'd17;
  localparam logic [5:0] S_THA = 6'd18;
  localparam logic [5:0] S_THB = 6'd19;
  localparam logic [5:0] S_THC = 6'd20;
  localparam logic [5:0] S_THD = 6'd21;
  localparam logic [5:0] S_THE = 6'd22;
  localparam logic [5:0] S_THF = 6'd23;
  localparam logic [5:0] S_THG = 6'd24;
  localparam logic [5:0] S_THH = 6'd25;
  localparam logic [5:0] S_M0 = 6'd26;
  localparam logic [5:0] S_M1 = 6'd27;
  localparam logic [5:0] S_M2 = 6'd28;
  localparam logic [5:0] S_M3 = 6'd29;
  localparam logic [5:0] S_M4 = 6'd30;
  localparam logic [5:0] S_M5 = 6'd31;
  localparam logic [5:0] S_M6 = 6'd32;
  localparam logic [5:0] S_M7 = 6'd33;
  localparam logic [5:0] S_M8 = 6'd34;
  localparam logic [5:0] S_M9 = 6'd35;
  localparam logic [5:0] S_M10 = 6'd36;
  localparam logic [5:0] S_M11 = 6'd37;
  localparam logic [5:0] S_M12 = 6'd38;
  localparam logic [5:0] S_M13 = 6'd39;
  localparam logic [5:0] S_SET = 6'd40;

  localparam logic [5:0] CNT_LAST = 6'd63;
  localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

  function automatic logic signed [MW-1:0] clamp_one(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v > ONE_Q30 ? ONE_Q30 : (v < -ONE_Q30 ? -ONE_Q30 : v);
    return r[MW-1:0];
  endfunction

  logic [1:0] phase_r;
  logic [5:0] step_r, cnt_r;
  logic ok_r;

  logic signed [63:0] t0_r, t_r, t02_r, t2_r, t3_r, lin_r, lt_r, u_r, ang_r, w_r;
  logic signed [63:0] m_r [8];
  logic [31:0] turn_r;
  logic signed [CW-1:0] sze_r, cze_r, sz_r, cz_r, sth_r, cth_r;
  epr_pkg::row_t [2:0] rows_r;

  logic [127:0] mc_r, pacc_r;
  logic [63:0] mp_r;
  logic neg_r;

  logic [2:0] op;
  logic signed [63:0] opa, opb;
  logic dturn;
  logic [63:0] ua, ub, dvd, rcp, quo_mag;
  logic signed [63:0] df0, df1, num0, num1;
  logic [127:0] prod;
  logic signed [63:0] p, quo;

  logic cor_start, cor_done;
  logic signed [CW-1:0] cor_sin, cor_cos;

  epr_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .ang_i(turn_r),
    .done_o(cor_done), .sin_o(cor_sin), .cos_o(cor_cos)
  );

  always_comb begin
    df0 = signed'({{(64-EW){1'b0}}, epoch_from})
        - signed'({{(64-EW){1'b0}}, epr_pkg::EPOCH_J2000});
    df1 = signed'({{(64-EW){1'b0}}, epoch_to}) - signed'({{(64-EW){1'b0}}, epoch_from});
    num0 = df0 <<< 16;
    num1 = df1 <<< 16;
  end

  always_comb begin
    op = OP_SET;
    opa = '0;
    opb = '0;
    dturn = 1'b0;
    case (step_r)
      S_T0: begin op = OP_DIV; opa = num0; end
      S_T: begin op = OP_DIV; opa = num1; end
      S_T02: begin op = OP_M32; opa = t0_r; opb = t0_r; end
      S_T2: begin op = OP_M32; opa = t_r; opb = t_r; end
      S_T3: begin op = OP_M32; opa = t2_r; opb = t_r; end
      S_LA: begin op = OP_M32; opa = epr_pkg::K_LIN1; opb = t0_r; end
      S_LB: begin op = OP_M32; opa = epr_pkg::K_LIN2; opb = t02_r; end
      S_LT: begin op = OP_M32; opa = lin_r; opb = t_r; end
      S_ZEA: begin op = OP_M32; opa = epr_pkg::K_ZE2T; opb = t0_r; end
      S_ZEB: begin op = OP_M32; opa = u_r; opb = t2_r; end
      S_ZEC: begin op = OP_M32; opa = epr_pkg::K_ZE3; opb = t3_r; end
      S_ZED: begin op = OP_DIV; opa = ang_r; dturn = 1'b1; end
      S_ZEE: op = OP_COR;
      S_ZA: begin op = OP_M32; opa = epr_pkg::K_Z2T; opb = t0_r; end
      S_ZB: begin op = OP_M32; opa = u_r; opb = t2_r; end
      S_ZC: begin op = OP_M32; opa = epr_pkg::K_Z3; opb = t3_r; end
      S_ZD: begin op = OP_DIV; opa = ang_r; dturn = 1'b1; end
      S_ZE: op = OP_COR;
      S_THA: begin op = OP_M32; opa = epr_pkg::K_TH1T; opb = t0_r; end
      S_THB: begin op = OP_M32; opa = epr_pkg::K_TH217; opb = t02_r; end
      S_THC: begin op = OP_M32; opa = u_r; opb = t_r; end
      S_THD: begin op = OP_M32; opa = epr_pkg::K_TH217; opb = t0_r; end
      S_THE: begin op = OP_M32; opa = u_r; opb = t2_r; end
      S_THF: begin op = OP_M32; opa = epr_pkg::K_TH3; opb = t3_r; end
      S_THG: begin op = OP_DIV; opa = ang_r; dturn = 1'b1; end
      S_THH: op = OP_COR;
      S_M0: begin op = OP_M30; opa = 64'(cz_r); opb = 64'(cth_r); end
      S_M1: begin op = OP_M30; opa = w_r; opb = 64'(cze_r); end
      S_M2: begin op = OP_M30; opa = 64'(sz_r); opb = 64'(sze_r); end
      S_M3: begin op = OP_M30; opa = w_r; opb = 64'(sze_r); end
      S_M4: begin op = OP_M30; opa = 64'(sz_r); opb = 64'(cze_r); end
      S_M5: begin op = OP_M30; opa = 64'(cz_r); opb = 64'(sth_r); end
      S_M6: begin op = OP_M30; opa = 64'(sz_r); opb = 64'(cth_r); end
      S_M7: begin op = OP_M30; opa = w_r; opb = 64'(cze_r); end
      S_M8: begin op = OP_M30; opa = 64'(cz_r); opb = 64'(sze_r); end
      S_M9: begin op = OP_M30; opa = w_r; opb = 64'(sze_r); end
      S_M10: begin op = OP_M30; opa = 64'(cz_r); opb = 64'(cze_r); end
      S_M11: begin op = OP_M30; opa = 64'(sz_r); opb = 64'(sth_r); end
      S_M12: begin op = OP_M30; opa = 64'(sth_r); opb = 64'(cze_r); end
      S_M13: begin op = OP_M30; opa = 64'(sth_r); opb = 64'(sze_r); end
      default: op = OP_SET;
    endcase
  end

  always_comb begin
    ua = opa[63] ? ~opa + 64'd1 : opa;
    ub = opb[63] ? ~opb + 64'd1 : opb;
    dvd = (op == OP_DIV && dturn) ? (ua >> epr_pkg::TURN_PRESH) : ua;
    rcp = dturn ? epr_pkg::RECIP_TURN : epr_pkg::RECIP_CENT;
    prod = neg_r ? ~pacc_r + 128'd1 : pacc_r;
    p = (op == OP_M30) ? signed'(prod[93:30]) : signed'(prod[95:32]);
    quo_mag = {{(RS-64){1'b0}}, pacc_r[127:RS]};
    quo = neg_r ? signed'(~quo_mag + 64'd1) : signed'(quo_mag);
    cor_start = (phase_r == PH_ISSUE) && (op == OP_COR) && !start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      step_r <= S_T0;
      cnt_r <= '0;
      ok_r <= 1'b0;
    end else if (start) begin
      phase_r <= PH_ISSUE;
      step_r <= S_T0;
      ok_r <= 1'b0;
    end else begin
      case (phase_r)
        PH_ISSUE: begin
          cnt_r <= '0;
          phase_r <= (op == OP_SET) ? PH_WB : PH_RUN;
        end
        PH_RUN: begin
          if (op == OP_COR) begin
            if (cor_done) phase_r <= PH_WB;
          end else begin
            cnt_r <= cnt_r + 6'd1;
            if (cnt_r == CNT_LAST) phase_r <= PH_WB;
          end
        end
        PH_WB: begin
          if (step_r == S_SET) begin
            phase_r <= PH_IDLE;
            ok_r <= 1'b1;
          end else begin
            step_r <= step_r + 6'd1;
            phase_r <= PH_ISSUE;
          end
        end
        default: phase_r <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == PH_ISSUE) begin
      mc_r <= {64'd0, dvd};
      mp_r <= (op == OP_DIV) ? rcp : ub;
      pacc_r <= '0;
      neg_r <= (op == OP_DIV) ? opa[63] : (opa[63] ^ opb[63]);
    end
    if (phase_r == PH_RUN) begin
      if (mp_r[0]) pacc_r <= pacc_r + mc_r;
      mc_r <= mc_r << 1;
      mp_r <= mp_r >> 1;
    end
    if (phase_r == PH_WB) begin
      case (step_r)
        S_T0: t0_r <= quo;
        S_T: t_r <= quo;
        S_T02: t02_r <= p;
        S_T2: t2_r <= p;
        S_T3: t3_r <= p;
        S_LA: lin_r <= epr_pkg::K_LIN0 + p;
        S_LB: lin_r <= lin_r - p;
        S_LT: lt_r <= p;
        S_ZEA: u_r <= epr_pkg::K_ZE2 - p;
        S_ZEB: ang_r <= lt_r + p;
        S_ZEC: ang_r <= ang_r + p;
        S_ZED: turn_r <= quo[31:0];
        S_ZEE: begin sze_r <= cor_sin; cze_r <= cor_cos; end
        S_ZA: u_r <= epr_pkg::K_Z2 + p;
        S_ZB: ang_r <= lt_r + p;
        S_ZC: ang_r <= ang_r + p;
        S_ZD: turn_r <= quo[31:0];
        S_ZE: begin sz_r <= cor_sin; cz_r <= cor_cos; end
        S_THA: u_r <= epr_pkg::K_TH1 - p;
        S_THB: u_r <= u_r - p;
        S_THC: ang_r <= p;
        S_THD: u_r <= epr_pkg::K_TH2 + p;
        S_THE: ang_r <= ang_r - p;
        S_THF: ang_r <= ang_r - p;
        S_THG: turn_r <= quo[31:0];
        S_THH: begin sth_r <= cor_sin; cth_r <= cor_cos; end
        S_M0: w_r <= p;
        S_M1: m_r[0] <= p;
        S_M2: m_r[0] <= m_r[0] - p;
        S_M3: m_r[1] <= -p;
        S_M4: m_r[1] <= m_r[1] - p;
        S_M5: m_r[2] <= -p;
        S_M6: w_r <= p;
        S_M7: m_r[3] <= p;
        S_M8: m_r[3] <= m_r[3] + p;
        S_M9: m_r[4] <= -p;
        S_M10: m_r[4] <= m_r[4] + p;
        S_M11: m_r[5] <= -p;
        S_M12: m_r[6] <= p;
        S_M13: m_r[7] <= -p;
        S_SET: begin
          rows_r[0].c0 <= clamp_one(m_r[0]);
          rows_r[0].c1 <= clamp_one(m_r[1]);
          rows_r[0].c2 <= clamp_one(m_r[2]);
          rows_r[1].c0 <= clamp_one(m_r[3]);
          rows_r[1].c1 <= clamp_one(m_r[4]);
          rows_r[1].c2 <= clamp_one(m_r[5]);
          rows_r[2].c0 <= clamp_one(m_r[6]);
          rows_r[2].c1 <= clamp_one(m_r[7]);
          rows_r[2].c2 <= clamp_one(64'(cth_r));
        end
        default: ;
      endcase
    end
  end

  assign mat_o.ok = ok_r;
  assign mat_o.rows = rows_r;
endmodule

// ----- design/epr_lane.sv -----
// One matrix row times the vector: registered products, then sum, Q30 shift
// and saturation. Depends on epr_pkg.
module epr_lane (
  input  logic clk,
  input  logic load,
  input  epr_pkg::row_t row_i,
  input  epr_pkg::coord_t vx,
  input  epr_pkg::coord_t vy,
  input  epr_pkg::coord_t vz,
  output epr_pkg::coord_t res_o
);
  localparam int PW = epr_pkg::PROD_W;
  localparam int SW = epr_pkg::SUM_W;
  localparam int CWD = epr_pkg::COORD_WIDTH;
  localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (CWD - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  logic signed [PW-1:0] p0_r, p1_r, p2_r;
  logic signed [SW-1:0] sum, sh;

  always_ff @(posedge clk) begin
    if (load) begin
      p0_r <= PW'(row_i.c0) * PW'(vx);
      p1_r <= PW'(row_i.c1) * PW'(vy);
      p2_r <= PW'(row_i.c2) * PW'(vz);
    end
  end

  always_comb begin
    sum = SW'(p0_r) + SW'(p1_r) + SW'(p2_r);
    sh = sum >>> epr_pkg::MAT_FRAC;
    if (sh > SAT_HI) res_o = SAT_HI[CWD-1:0];
    else if (sh < SAT_LO) res_o = SAT_LO[CWD-1:0];
    else res_o = sh[CWD-1:0];
  end
endmodule

// ----- design/epr_merge.sv -----
// Output register: gathers the three lane results into one result word.
// Depends on epr_pkg and epr_out_if.
module epr_merge (
  input  logic clk,
  input  logic rst_n,
  input  epr_pkg::pipe_ctl_t ctl_i,
  input  epr_pkg::coord_t rx,
  input  epr_pkg::coord_t ry,
  input  epr_pkg::coord_t rz,
  epr_out_if.source out_ch
);
  logic valid_r;
  epr_pkg::coord_t x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (ctl_i.adv) valid_r <= ctl_i.vp;
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv && ctl_i.vp) begin
      x_r <= rx;
      y_r <= ry;
      z_r <= rz;
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.rot_x = x_r;
  assign out_ch.rot_y = y_r;
  assign out_ch.rot_z = z_r;
endmodule

// ----- sim/testbench.sv -----
// Testbench for equatorial_precession_rotate: streams vectors through the rotator
// under several epoch settings and scores each word against a local model or table.
// Depends on epr_pkg, epr_in_if, epr_out_if and the rotator RTL.
`timescale 1ns / 1ps

module testbench;

  typedef logic signed [127:0] s128_t;
  typedef struct {
    epr_pkg::coord_t x;
    epr_pkg::coord_t y;
    epr_pkg::coord_t z;
  } vec_t;

  typedef struct {
    epr_pkg::coord_t x;
    epr_pkg::coord_t y;
    epr_pkg::coord_t z;
    bit     typed;
    epr_pkg::coord_t ex;
    epr_pkg::coord_t ey;
    epr_pkg::coord_t ez;
  } stim_row_t;

  localparam longint J2000 = 64'sd160664453120;
  localparam longint unsigned EPOCH_MAX = (64'd1 << epr_pkg::EPOCH_W) - 1;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [epr_pkg::CFG_AW-1:0] cfg_paddr;
  logic [epr_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [epr_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  epr_in_if in_ch();
  epr_out_if out_ch();

  equatorial_precession_rotate dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  longint unsigned epoch_from;
  longint unsigned epoch_to;
  longint rot_mat [3][3];
  vec_t expected_rot_q[$];
  int errors;
  int idle_cycles;
  bit no_idle;
  bit hold_req;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint mq32(longint a, longint b);
    s128_t p;
    p = s128_t'(a) * s128_t'(b);
    return longint'(p >>> 32);
  endfunction

  function automatic longint m30(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint arcsec_coef(longint unsigned micro);
    return longint'(((micro << 32) + 64'd500000) / 64'd1000000);
  endfunction

  function automatic logic [31:0] arcsec_to_turns(longint a);
    longint q;
    q = a / longint'(1296000);
    return q[31:0];
  endfunction

  task automatic cordic_sincos(input logic [31:0] ang, output longint s, output longint c);
    logic [31:0] tmp;
    logic [31:0] a;
    bit flip;
    longint x, y, z, dx, dy;
    tmp = ang + 32'h4000_0000;
    flip = tmp[31];
    a = flip ? ang + 32'h8000_0000 : ang;
    z = longint'(int'(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < epr_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(epr_pkg::ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(epr_pkg::ATAN_TAB[i]);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  task automatic build_precession_matrix();
    longint t0, t, t02, t2, t3, lin, zeta, zz, th;
    longint sze, cze, sz, cz, sth, cth;
    t0 = (longint'(epoch_from) - J2000) * 65536 / 36525;
    t = (longint'(epoch_to) - longint'(epoch_from)) * 65536 / 36525;
    t02 = mq32(t0, t0);
    t2 = mq32(t, t);
    t3 = mq32(t2, t);
    lin = arcsec_coef(2306218100) + mq32(arcsec_coef(1396560), t0)
        - mq32(arcsec_coef(139), t02);
    zeta = mq32(lin, t) + mq32(arcsec_coef(301880) - mq32(arcsec_coef(344), t0), t2)
         + mq32(arcsec_coef(17998), t3);
    zz = mq32(lin, t) + mq32(arcsec_coef(1094680) + mq32(arcsec_coef(66), t0), t2)
       + mq32(arcsec_coef(18203), t3);
    th = mq32(arcsec_coef(2004310900) - mq32(arcsec_coef(853300), t0)
              - mq32(arcsec_coef(217), t02), t)
       - mq32(arcsec_coef(426650) + mq32(arcsec_coef(217), t0), t2)
       - mq32(arcsec_coef(41833), t3);
    cordic_sincos(arcsec_to_turns(zeta), sze, cze);
    cordic_sincos(arcsec_to_turns(zz), sz, cz);
    cordic_sincos(arcsec_to_turns(th), sth, cth);
    rot_mat[0][0] = m30(m30(cz, cth), cze) - m30(sz, sze);
    rot_mat[0][1] = -m30(m30(cz, cth), sze) - m30(sz, cze);
    rot_mat[0][2] = -m30(cz, sth);
    rot_mat[1][0] = m30(m30(sz, cth), cze) + m30(cz, sze);
    rot_mat[1][1] = -m30(m30(sz, cth), sze) + m30(cz, cze);
    rot_mat[1][2] = -m30(sz, sth);
    rot_mat[2][0] = m30(sth, cze);
    rot_mat[2][1] = -m30(sth, sze);
    rot_mat[2][2] = cth;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        if (rot_mat[i][j] > ONE_Q30) rot_mat[i][j] = ONE_Q30;
        if (rot_mat[i][j] < -ONE_Q30) rot_mat[i][j] = -ONE_Q30;
      end
  endtask

  function automatic vec_t precess_vec(epr_pkg::coord_t x, epr_pkg::coord_t y,
                                       epr_pkg::coord_t z);
    s128_t acc;
    epr_pkg::coord_t r [3];
    vec_t v;
    for (int i = 0; i < 3; i++) begin
      acc = s128_t'(rot_mat[i][0]) * s128_t'(x) + s128_t'(rot_mat[i][1]) * s128_t'(y)
          + s128_t'(rot_mat[i][2]) * s128_t'(z);
      acc = acc >>> 30;
      if (acc > s128_t'(32'sh7FFF_FFFF)) r[i] = 32'sh7FFF_FFFF;
      else if (acc < -s128_t'(64'sd2147483648)) r[i] = 32'sh8000_0000;
      else r[i] = acc[31:0];
    end
    v.x = r[0];
    v.y = r[1];
    v.z = r[2];
    return v;
  endfunction

  task automatic wait_drained();
    while (expected_rot_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_epoch(int idx, logic [epr_pkg::CFG_DW-1:0] val);
    @(posedge clk);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= epr_pkg::CFG_AW'(idx * 8);
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    if (idx == 0) epoch_from = val & EPOCH_MAX;
    else epoch_to = val & EPOCH_MAX;
    build_precession_matrix();
  endtask

  task automatic set_epochs(logic [epr_pkg::CFG_DW-1:0] from_v,
                            logic [epr_pkg::CFG_DW-1:0] to_v);
    wait_drained();
    write_epoch(0, from_v);
    write_epoch(1, to_v);
  endtask

  task automatic send_vec(epr_pkg::coord_t x, epr_pkg::coord_t y, epr_pkg::coord_t z,
                          bit typed, vec_t ev);
    while (!no_idle && $urandom_range(99) < 21) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.vec_x <= x;
    in_ch.vec_y <= y;
    in_ch.vec_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    expected_rot_q.push_back(typed ? ev : precess_vec(x, y, z));
  endtask

  task automatic stop_sending();
    in_ch.valid <= 0;
    @(posedge clk);
  endtask

  function automatic epr_pkg::coord_t rand_coord();
    case ($urandom_range(3))
      0: return epr_pkg::coord_t'($urandom_range(32'h4000_0000)) - 32'sh2000_0000;
      1: return epr_pkg::coord_t'(int'($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
      default: return epr_pkg::coord_t'($urandom());
    endcase
  endfunction

  function automatic logic [epr_pkg::CFG_DW-1:0] rand_epoch();
    longint span;
    case ($urandom_range(2))
      0: begin
        span = longint'($urandom_range(32'h7FFF_FFFF)) <<< 5;
        return ($urandom_range(1) ? J2000 + span : J2000 - span);
      end
      1: return {$urandom(), $urandom()} & EPOCH_MAX;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // sink side: random stalls, long hold-off on request
  initial begin
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= 21);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rot_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h %h %h",
                                     out_ch.rot_x, out_ch.rot_y, out_ch.rot_z);
        end else begin
          vec_t e;
          e = expected_rot_q.pop_front();
          if (e.x !== out_ch.rot_x || e.y !== out_ch.rot_y || e.z !== out_ch.rot_z) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp %h %h %h got %h %h %h", e.x, e.y, e.z,
                       out_ch.rot_x, out_ch.rot_y, out_ch.rot_z);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  stim_row_t dir_tab [12];
  vec_t zero_v;

  initial begin
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.vec_x = 0;
    in_ch.vec_y = 0;
    in_ch.vec_z = 0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = 0;
    cfg_pwdata = 0;
    errors = 0;
    idle_cycles = 0;
    no_idle = 0;
    hold_req = 0;
    zero_v = '{0, 0, 0};
    dir_tab[0] = '{0, 0, 0, 1, 0, 0, 0};
    dir_tab[1] = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 0};
    dir_tab[2] = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0};
    dir_tab[3] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 0};
    dir_tab[4] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0};
    dir_tab[5] = '{32'sh4000_0000, 0, 0, 0, 0, 0, 0};
    dir_tab[6] = '{0, 32'sh4000_0000, 0, 0, 0, 0, 0};
    dir_tab[7] = '{0, 0, 32'sh4000_0000, 0, 0, 0, 0};
    dir_tab[8] = '{32'shC000_0000, 32'shC000_0000, 32'shC000_0000, 0, 0, 0, 0};
    dir_tab[9] = '{-1, -1, -1, 0, 0, 0, 0};
    dir_tab[10] = '{1, 1, 1, 0, 0, 0, 0};
    dir_tab[11] = '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 0, 0, 0, 0};
    epoch_from = J2000;
    epoch_to = J2000;
    build_precession_matrix();
    repeat (10) @(posedge clk);
    rst_n <= 1;

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) set_epochs(0, 64'hFFFF_FFFF_FFFF_FFFF);
      if (ph == 2) set_epochs(EPOCH_MAX, 0);
      foreach (dir_tab[i])
        send_vec(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].typed,
                 '{dir_tab[i].ex, dir_tab[i].ey, dir_tab[i].ez});
      stop_sending();
    end

    for (int ph = 0; ph < 11; ph++) begin
      set_epochs(rand_epoch(), rand_epoch());
      no_idle = (ph == 4);
      for (int n = 0; n < 110; n++) begin
        if (ph == 2 && n == 20) hold_req = 1;
        if (ph == 6 && n == 50) begin
          stop_sending();
          while (expected_rot_q.size() != 0) @(posedge clk);
        end
        send_vec(rand_coord(), rand_coord(), rand_coord(), 0, zero_v);
      end
      stop_sending();
      no_idle = 0;
    end

    while (expected_rot_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
design/epr_pkg.sv
design/epr_in_if.sv
design/epr_out_if.sv
design/epr_cordic.sv
design/epr_mat_build.sv
design/epr_lane.sv
design/epr_merge.sv
design/equatorial_precession_rotate.sv
sim/testbench.sv
